@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tls_pkg.sv @@
// types, constants and helpers for the token scanner
`default_nettype none

package tls_pkg;

	localparam int LEN_W  = 8;
	localparam int LINE_W = 16;

	localparam logic [LEN_W-1:0]  LEN_MAX  = 8'd255;
	localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_EOS    = 8'hFF;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_S      = 8'h73;

	typedef enum logic [3:0] {
		TK_ID      = 4'd0,
		TK_STR     = 4'd1,
		TK_PLUS    = 4'd2,
		TK_STAR    = 4'd3,
		TK_SET     = 4'd4,
		TK_PRINT   = 4'd5,
		TK_LPAREN  = 4'd6,
		TK_RPAREN  = 4'd7,
		TK_LEFTSQ  = 4'd8,
		TK_RIGHTSQ = 4'd9,
		TK_SC      = 4'd10,
		TK_ERR     = 4'd11,
		TK_DONE    = 4'd12
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  len;
		logic [LINE_W-1:0] line;
		logic              last;
	} tok_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	// keyword letters by position
	function automatic logic [7:0] kw_print_char(input logic [2:0] idx);
		case (idx)
			3'd0:    kw_print_char = 8'h70;
			3'd1:    kw_print_char = 8'h72;
			3'd2:    kw_print_char = 8'h69;
			3'd3:    kw_print_char = 8'h6E;
			default: kw_print_char = 8'h74;
		endcase
	endfunction

	function automatic logic [7:0] kw_set_char(input logic [1:0] idx);
		case (idx)
			2'd0:    kw_set_char = 8'h73;
			2'd1:    kw_set_char = 8'h65;
			default: kw_set_char = 8'h74;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/toy_language_token_scanner.sv @@
// character-serial token scanner for a toy language
// an accepted character lands in the input register and is scanned from there; its
//   tokens are written into the four-entry token queue, whose head drives the output
// throughput: one character per cycle while the queue has room for two tokens; a
//   character yielding two tokens is taken whole, the queue absorbs the extra token
// stall: input stalls only when the token queue holds more than two tokens
// reset: arst_n clears scanner state to idle, line count to zero, queue empty
`default_nettype none

module toy_language_token_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] lexeme_length, [23:8] line_number
	output logic [3:0]       m_tuser,   // [3:0] token_kind
	output logic             m_tlast    // last_of_run
);

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_IDENT,
		MODE_STRING
	} mode_t;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// scanner state
	mode_t                      mode_q, mode_d;
	logic [tls_pkg::LEN_W-1:0]  len_q, len_d;
	logic                       pm_q, pm_d;      // still matches "print"
	logic                       sm_q, sm_d;      // still matches "set"
	logic [tls_pkg::LINE_W-1:0] line_q, line_d;

	// token queue
	tls_pkg::tok_t fifo_q [4];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    fill_q;

	// scan results
	tls_pkg::tok_t res0, res1, tok_new;
	logic [1:0]    res_n;
	logic          idle_go, new_flag;
	tls_pkg::kind_t id_kind;

	logic advance, pop;
	logic [tls_pkg::LINE_W-1:0] line_inc1, line_inc2;
	logic [tls_pkg::LEN_W-1:0]  len_inc;

	// scan proceeds when the queue has room for two tokens
	assign advance  = valid_s1 && (fill_q <= 3'd2);
	assign s_tready = !valid_s1 || advance;
	assign pop      = m_tvalid && m_tready;

	assign line_inc1 = (line_q == tls_pkg::LINE_MAX) ? line_q : line_q + 16'd1;
	assign line_inc2 = (line_q >= tls_pkg::LINE_MAX - 16'd1) ? tls_pkg::LINE_MAX
		: line_q + 16'd2;
	assign len_inc   = (len_q == tls_pkg::LEN_MAX) ? len_q : len_q + 8'd1;

	// one pass over the current character: next state and up to two tokens
	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		pm_d     = pm_q;
		sm_d     = sm_q;
		line_d   = line_q;
		res0     = '0;
		res1     = '0;
		res_n    = 2'd0;
		idle_go  = 1'b0;
		new_flag = 1'b0;
		tok_new  = '0;
		id_kind  = tls_pkg::TK_ID;

		unique case (mode_q)
			MODE_SLASH: begin
				if (!eoi_s1 && char_s1 == tls_pkg::CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else begin
					idle_go = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (eoi_s1) begin
					mode_d = MODE_IDLE;
					res0   = '{tls_pkg::TK_DONE, 8'd0, line_q, 1'b0};
					res_n  = 2'd1;
				end else if (char_s1 == tls_pkg::CH_NL) begin
					line_d = line_inc1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_IDENT: begin
				if (!eoi_s1 && tls_pkg::is_letter(char_s1)) begin
					pm_d  = pm_q && (len_q < 8'd5)
						&& (char_s1 == tls_pkg::kw_print_char(len_q[2:0]));
					sm_d  = sm_q && (len_q < 8'd3)
						&& (char_s1 == tls_pkg::kw_set_char(len_q[1:0]));
					len_d = len_inc;
				end else begin
					if (pm_q && len_q == 8'd5) begin
						id_kind = tls_pkg::TK_PRINT;
					end else if (sm_q && len_q == 8'd3) begin
						id_kind = tls_pkg::TK_SET;
					end
					res0    = '{id_kind, len_q, line_q, 1'b0};
					res_n   = 2'd1;
					idle_go = 1'b1;
				end
			end
			MODE_STRING: begin
				if (eoi_s1) begin
					mode_d = MODE_IDLE;
					res0   = '{tls_pkg::TK_ERR, len_q, line_q, 1'b0};
					res_n  = 2'd1;
				end else if (char_s1 == tls_pkg::CH_QUOTE) begin
					mode_d = MODE_IDLE;
					res0   = '{tls_pkg::TK_STR, len_q, line_q, 1'b0};
					res_n  = 2'd1;
				end else if (char_s1 == tls_pkg::CH_NL) begin
					// newline inside a string counts twice, error shows the new count
					line_d = line_inc2;
					mode_d = MODE_IDLE;
					res0   = '{tls_pkg::TK_ERR, len_q, line_inc2, 1'b0};
					res_n  = 2'd1;
				end else begin
					len_d = len_inc;
				end
			end
			default: begin
				idle_go = 1'b1;
			end
		endcase

		// fresh scan of the character from idle; line_d is still line_q here
		if (idle_go) begin
			mode_d = MODE_IDLE;
			if (eoi_s1 || char_s1 == tls_pkg::CH_EOS) begin
				tok_new  = '{tls_pkg::TK_DONE, 8'd0, line_q, 1'b0};
				new_flag = 1'b1;
			end else begin
				case (char_s1) inside
					tls_pkg::CH_SPACE, tls_pkg::CH_TAB: ;
					tls_pkg::CH_NL:     line_d = line_inc1;
					tls_pkg::CH_SLASH:  mode_d = MODE_SLASH;
					tls_pkg::CH_QUOTE: begin
						mode_d = MODE_STRING;
						len_d  = 8'd0;
					end
					tls_pkg::CH_PLUS: begin
						tok_new  = '{tls_pkg::TK_PLUS, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_STAR: begin
						tok_new  = '{tls_pkg::TK_STAR, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_SEMI: begin
						tok_new  = '{tls_pkg::TK_SC, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_LSQ: begin
						tok_new  = '{tls_pkg::TK_LEFTSQ, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_RSQ: begin
						tok_new  = '{tls_pkg::TK_RIGHTSQ, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_LPAREN: begin
						tok_new  = '{tls_pkg::TK_LPAREN, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					tls_pkg::CH_RPAREN: begin
						tok_new  = '{tls_pkg::TK_RPAREN, 8'd1, line_q, 1'b0};
						new_flag = 1'b1;
					end
					default: begin
						if (tls_pkg::is_letter(char_s1)) begin
							mode_d = MODE_IDENT;
							len_d  = 8'd1;
							pm_d   = (char_s1 == tls_pkg::CH_P);
							sm_d   = (char_s1 == tls_pkg::CH_S);
						end else begin
							tok_new  = '{tls_pkg::TK_ERR, 8'd0, line_q, 1'b0};
							new_flag = 1'b1;
						end
					end
				endcase
			end
		end

		// the idle token follows any token already produced
		if (new_flag) begin
			if (res_n == 2'd0) begin
				res0 = tok_new;
			end else begin
				res1 = tok_new;
			end
			res_n = res_n + 2'd1;
		end

		// mark the final token of this character
		if (res_n == 2'd1) begin
			res0.last = 1'b1;
		end else if (res_n == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			pm_q   <= 1'b1;
			sm_q   <= 1'b1;
			line_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			pm_q   <= pm_d;
			sm_q   <= sm_d;
			line_q <= line_d;
		end
	end

	// token queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= advance ? wr_ptr_q + res_n : wr_ptr_q;
			rd_ptr_q <= pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
			fill_q   <= fill_q + (advance ? {1'b0, res_n} : 3'd0) - {2'b00, pop};
		end
	end

	// token queue storage
	always_ff @(posedge clk) begin
		if (advance && res_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (advance && res_n == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	assign m_tvalid = (fill_q != 3'd0);
	assign m_tuser  = fifo_q[rd_ptr_q].kind;
	assign m_tdata  = {fifo_q[rd_ptr_q].line, fifo_q[rd_ptr_q].len};
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// queue never overfills
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= 3'd4, "token queue overflow")
	// end of input inside a string always returns to idle
	`ASSERT_NEXT(a_str_eoi_idle, clk, arst_n, advance && mode_q == MODE_STRING && eoi_s1,
		mode_q == MODE_IDLE, "string not closed on end of input")
	// line count only grows
	`ASSERT_ALWAYS(a_line_mono, clk, arst_n, line_q >= $past(line_q), "line count went back")
	// input stalls only behind a held character and a busy queue
	`ASSERT_ALWAYS(a_stall_cause, clk, arst_n, s_tready || (valid_s1 && fill_q > 3'd2),
		"input stalled without cause")

endmodule

`default_nettype wire

@@ tb/sv/tb_toy_language_token_scanner.sv @@
// self-checking testbench for the toy language token scanner
module tb_toy_language_token_scanner;
	timeunit 1ns;
	timeprecision 1ps;

	// no-progress limit: covers the long receiver hold plus random idling with margin
	localparam int unsigned QUIET_LIMIT = 3000;
	// output settle time after the last token
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 300;

	// scanner modes of the predictor
	typedef enum logic [2:0] {
		SC_IDLE,
		SC_SLASH,
		SC_COMMENT,
		SC_IDENT,
		SC_STRING
	} scan_mode_t;

	// one source byte as offered on the input stream
	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} char_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
	logic        s_tlast = 1'b0;    // end_of_input
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [7:0] lexeme_length, [23:8] line_number
	logic [3:0]  m_tuser;           // [3:0] token_kind
	logic        m_tlast;           // last_of_run

	toy_language_token_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// source bytes waiting to be offered, and tokens the scanner still owes us
	char_item_t     pend_chars[$];
	tls_pkg::tok_t  owed_toks[$];
	tls_pkg::tok_t  step_toks[$];

	// predictor state
	scan_mode_t  mode = SC_IDLE;
	int unsigned text_len = 0;
	logic        print_ok = 1'b1;
	logic        set_ok = 1'b1;
	logic [15:0] line_cnt = 16'd0;
	string       kw_print = "print";
	string       kw_set = "set";

	// bookkeeping
	int unsigned items_total = 0;
	int unsigned chars_in = 0;
	int unsigned toks_checked = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned max_len_seen = 0;
	int unsigned kind_seen[16];
	bit          in_went = 1'b0;

	// idling knobs, in percent of cycles
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          rx_hold_req = 1'b0;
	int unsigned rx_hold_left = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic bit letter_byte(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// line counter saturates instead of wrapping
	task automatic line_bump(int unsigned n);
		int unsigned sum;
		sum = line_cnt + n;
		line_cnt = (sum > tls_pkg::LINE_MAX) ? tls_pkg::LINE_MAX
			: sum[tls_pkg::LINE_W-1:0];
	endtask

	task automatic text_grow();
		if (text_len < tls_pkg::LEN_MAX)
			text_len++;
	endtask

	task automatic emit_tok(tls_pkg::kind_t k, int unsigned len);
		tls_pkg::tok_t t;
		t.kind = k;
		t.len  = (len > tls_pkg::LEN_MAX) ? tls_pkg::LEN_MAX : len[tls_pkg::LEN_W-1:0];
		t.line = line_cnt;
		t.last = 1'b0;
		step_toks = {step_toks, t};
	endtask

	// a byte seen with no token in progress
	task automatic scan_fresh(logic [7:0] c, logic eoi);
		mode = SC_IDLE;
		if (eoi || c == tls_pkg::CH_EOS) begin
			emit_tok(tls_pkg::TK_DONE, 0);
		end else begin
			case (c)
				tls_pkg::CH_SPACE, tls_pkg::CH_TAB: ;
				tls_pkg::CH_NL:     line_bump(1);
				tls_pkg::CH_SLASH:  mode = SC_SLASH;
				tls_pkg::CH_QUOTE: begin
					mode = SC_STRING;
					text_len = 0;
				end
				tls_pkg::CH_PLUS:   emit_tok(tls_pkg::TK_PLUS, 1);
				tls_pkg::CH_STAR:   emit_tok(tls_pkg::TK_STAR, 1);
				tls_pkg::CH_SEMI:   emit_tok(tls_pkg::TK_SC, 1);
				tls_pkg::CH_LSQ:    emit_tok(tls_pkg::TK_LEFTSQ, 1);
				tls_pkg::CH_RSQ:    emit_tok(tls_pkg::TK_RIGHTSQ, 1);
				tls_pkg::CH_LPAREN: emit_tok(tls_pkg::TK_LPAREN, 1);
				tls_pkg::CH_RPAREN: emit_tok(tls_pkg::TK_RPAREN, 1);
				default: begin
					if (letter_byte(c)) begin
						mode = SC_IDENT;
						text_len = 1;
						print_ok = (c == kw_print[0]);
						set_ok = (c == kw_set[0]);
					end else begin
						emit_tok(tls_pkg::TK_ERR, 0);
					end
				end
			endcase
		end
	endtask

	// works out the tokens one accepted byte produces and queues them
	task automatic scan_predict(logic [7:0] c, logic eoi);
		tls_pkg::kind_t k;
		step_toks.delete();
		case (mode)
			SC_SLASH: begin
				if (!eoi && c == tls_pkg::CH_SLASH)
					mode = SC_COMMENT;
				else
					scan_fresh(c, eoi);
			end
			SC_COMMENT: begin
				if (eoi) begin
					mode = SC_IDLE;
					emit_tok(tls_pkg::TK_DONE, 0);
				end else if (c == tls_pkg::CH_NL) begin
					line_bump(1);
					mode = SC_IDLE;
				end
			end
			SC_IDENT: begin
				if (!eoi && letter_byte(c)) begin
					print_ok = print_ok && text_len < 5 && c == kw_print[text_len];
					set_ok = set_ok && text_len < 3 && c == kw_set[text_len];
					text_grow();
				end else begin
					// the terminator is scanned again as a fresh byte
					if (print_ok && text_len == 5)
						k = tls_pkg::TK_PRINT;
					else if (set_ok && text_len == 3)
						k = tls_pkg::TK_SET;
					else
						k = tls_pkg::TK_ID;
					emit_tok(k, text_len);
					scan_fresh(c, eoi);
				end
			end
			SC_STRING: begin
				if (eoi) begin
					// end of input inside a string is an error, no done after it
					mode = SC_IDLE;
					emit_tok(tls_pkg::TK_ERR, text_len);
				end else if (c == tls_pkg::CH_QUOTE) begin
					mode = SC_IDLE;
					emit_tok(tls_pkg::TK_STR, text_len);
				end else if (c == tls_pkg::CH_NL) begin
					line_bump(2);
					mode = SC_IDLE;
					emit_tok(tls_pkg::TK_ERR, text_len);
				end else begin
					text_grow();
				end
			end
			default: scan_fresh(c, eoi);
		endcase
		if (step_toks.size() != 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		owed_toks = {owed_toks, step_toks};
	endtask

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------

	task automatic add_ch(logic [7:0] c);
		char_item_t it;
		it.ch = c;
		it.eoi = 1'b0;
		pend_chars = {pend_chars, it};
		items_total++;
	endtask

	// char_code is a don't care under the end marker, so randomize it
	task automatic add_end();
		char_item_t it;
		it.ch = 8'($urandom_range(255));
		it.eoi = 1'b1;
		pend_chars = {pend_chars, it};
		items_total++;
	endtask

	task automatic add_word(string s);
		for (int i = 0; i < s.len(); i++)
			add_ch(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'("a" + $urandom_range(25));
		if ($urandom_range(3) == 0)
			c = c - 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] rand_punct();
		case ($urandom_range(6))
			0:       return tls_pkg::CH_PLUS;
			1:       return tls_pkg::CH_STAR;
			2:       return tls_pkg::CH_SEMI;
			3:       return tls_pkg::CH_LSQ;
			4:       return tls_pkg::CH_RSQ;
			5:       return tls_pkg::CH_LPAREN;
			default: return tls_pkg::CH_RPAREN;
		endcase
	endfunction

	function automatic logic [7:0] rand_space();
		case ($urandom_range(2))
			0:       return tls_pkg::CH_SPACE;
			1:       return tls_pkg::CH_TAB;
			default: return tls_pkg::CH_NL;
		endcase
	endfunction

	// any byte except the given two
	function automatic logic [7:0] rand_body(logic [7:0] not_a, logic [7:0] not_b);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == not_a || c == not_b);
		return c;
	endfunction

	task automatic add_ident(int unsigned len);
		repeat (len)
			add_ch(rand_letter());
	endtask

	task automatic add_string(int unsigned len);
		add_ch(tls_pkg::CH_QUOTE);
		repeat (len)
			add_ch(rand_body(tls_pkg::CH_QUOTE, tls_pkg::CH_NL));
		// mostly closed properly, sometimes broken by a newline or the end marker
		case ($urandom_range(9))
			0:       add_ch(tls_pkg::CH_NL);
			1:       add_end();
			default: add_ch(tls_pkg::CH_QUOTE);
		endcase
	endtask

	// mostly well-formed source text with random content, some noise mixed in
	task automatic add_random_source(int unsigned n);
		int unsigned target;
		target = items_total + n;
		while (items_total < target) begin
			case ($urandom_range(11))
				0, 1: add_ident($urandom_range(1, 8));
				2: begin
					case ($urandom_range(9))
						0, 1: add_word("print");
						2, 3: add_word("set");
						4:    add_word("prin");
						5:    add_word("prints");
						6:    add_word("se");
						7:    add_word("sets");
						8:    add_word("Print");
						default: add_word("sprint");
					endcase
				end
				3, 4: add_string($urandom_range(0, 8));
				5: begin
					add_word("//");
					repeat ($urandom_range(0, 10))
						add_ch(rand_body(tls_pkg::CH_NL, tls_pkg::CH_NL));
					if ($urandom_range(7) == 0)
						add_end();
					else
						add_ch(tls_pkg::CH_NL);
				end
				6, 7: add_ch(rand_punct());
				8:  add_ch(rand_space());
				9:  add_ch(tls_pkg::CH_SLASH);
				10: add_ch(8'($urandom_range(255)));
				default: begin
					if ($urandom_range(1) == 0)
						add_end();
					else
						add_ch(tls_pkg::CH_EOS);
				end
			endcase
			// tokens often sit right against each other to end identifiers early
			if ($urandom_range(1) == 0)
				add_ch(rand_space());
		end
	endtask

	// waits for the input to drain and every owed token to come out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (chars_in != items_total || owed_toks.size() != 0);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// driver, receiver, monitor
	// ---------------------------------------------------------------

	// source side: next item goes out once the current one has been taken
	always @(negedge clk) begin : drive_chars
		char_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_went) begin
			in_went = 1'b0;
			if (pend_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				it = pend_chars.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.ch;
				s_tlast <= it.eoi;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// token side: random backpressure, plus an occasional long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic report_mismatch(string what);
		$display("token %0d @%0t: %s", toks_checked, $realtime, what);
		errors++;
	endtask

	always @(posedge clk) begin : watch_tokens
		tls_pkg::tok_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				if (owed_toks.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0d", m_tuser));
				end else begin
					want = owed_toks.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
					if (m_tdata[7:0] !== want.len)
						report_mismatch($sformatf("length %0d, want %0d",
							m_tdata[7:0], want.len));
					if (m_tdata[23:8] !== want.line)
						report_mismatch($sformatf("line %0d, want %0d",
							m_tdata[23:8], want.line));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
					kind_seen[want.kind]++;
					if (want.len > max_len_seen)
						max_len_seen = want.len;
				end
				toks_checked++;
			end
			if (s_tvalid && s_tready) begin
				quiet_cycles = 0;
				scan_predict(s_tdata, s_tlast);
				in_went = 1'b1;
				chars_in++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d tokens still owed",
					quiet_cycles, owed_toks.size());
				$display("** toy_language_token_scanner: FAILED **");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 15;
		rx_idle_pct = 48;

		// every single-character token
		add_ch(tls_pkg::CH_PLUS);
		add_ch(tls_pkg::CH_STAR);
		add_ch(tls_pkg::CH_SEMI);
		add_ch(tls_pkg::CH_LSQ);
		add_ch(tls_pkg::CH_RSQ);
		add_ch(tls_pkg::CH_LPAREN);
		add_ch(tls_pkg::CH_RPAREN);
		// keyword ended by a token: two tokens from one byte
		add_word("print(");
		// keyword ended by a quote, byte 255 as string text, newline in the string
		add_word("set");
		add_ch(tls_pkg::CH_QUOTE);
		add_ch(tls_pkg::CH_EOS);
		add_ch(tls_pkg::CH_NL);
		// slash then byte 255 gives done
		add_ch(tls_pkg::CH_SLASH);
		add_ch(tls_pkg::CH_EOS);
		// end marker inside a comment
		add_word("//x");
		add_end();
		// end marker inside a string
		add_ch(tls_pkg::CH_QUOTE);
		add_end();
		// high and control bytes outside strings are errors
		add_ch(8'h80);
		add_ch(8'h00);
		wait_drained();

		add_random_source(85);
		wait_drained();

		tx_idle_pct = 48;
		rx_idle_pct = 15;
		add_random_source(85);
		wait_drained();

		// no idling; the receiver holds off long enough to back up the input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b1;
		add_random_source(20);
		// lexemes longer than the length field saturate
		add_ident(260);
		add_ch(tls_pkg::CH_SEMI);
		add_string(258);
		add_random_source(20);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("scanned %0d characters into %0d checked tokens: %0d keywords, %0d strings,",
			chars_in, toks_checked,
			kind_seen[tls_pkg::TK_PRINT] + kind_seen[tls_pkg::TK_SET],
			kind_seen[tls_pkg::TK_STR]);
		$display("%0d errors, %0d done, longest lexeme %0d, final line %0d, %0d mismatches",
			kind_seen[tls_pkg::TK_ERR], kind_seen[tls_pkg::TK_DONE], max_len_seen,
			line_cnt, errors);
		if (errors == 0 && owed_toks.size() == 0) begin
			$display("** toy_language_token_scanner: PASSED **");
		end else begin
			$display("** toy_language_token_scanner: FAILED **");
		end
		$finish;
	end

endmodule

@@ toy_language_token_scanner.f @@
+incdir+hw/rtl
hw/rtl/tls_pkg.sv
hw/rtl/toy_language_token_scanner.sv
tb/sv/tb_toy_language_token_scanner.sv
